[hdl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define AST_IMPLY(lbl, clk, rstn, ante, cons)
`define AST_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hdl/cfsm_pkg.sv]
package cfsm_pkg;

    localparam int STORE_DEPTH_DEF = 16;

    localparam logic [4:0] CAP_RESET = 5'd16;

    localparam logic [2:0] OP_ENQUEUE = 3'd0;
    localparam logic [2:0] OP_DEQUEUE = 3'd1;
    localparam logic [2:0] OP_PEEK    = 3'd2;
    localparam logic [2:0] OP_SEARCH  = 3'd3;
    localparam logic [2:0] OP_MINIMUM = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    localparam logic signed [31:0] NONE_WORD = 32'shFFFF_FFFF;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               found;
        logic [1:0]         status;
        logic [4:0]         entry_count;
        logic               is_empty;
        logic               is_full;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic enq;
        logic set_empty;
        logic clear;
        logic scan_init;
        logic scan_fetch;
        logic scan_step;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       scan_last;
    } t_dp_status;

endpackage

[hdl/cfsm_dp.sv]
`include "assert_macros.svh"

module cfsm_dp #(
    parameter int STORE_DEPTH = cfsm_pkg::STORE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cfsm_pkg::t_in          i_in,
    input  logic                   i_cfg_we,
    input  logic [4:0]             i_cfg_wdata,
    input  cfsm_pkg::t_dp_cmd      i_cmd,
    output cfsm_pkg::t_dp_status   o_status,
    output cfsm_pkg::t_out         o_result
);

    localparam int IDX_W    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int NW       = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;
    localparam int DEPTH_LIM = (STORE_DEPTH > 31) ? 31 : STORE_DEPTH;
    localparam logic [4:0] CAP_MAX = 5'(DEPTH_LIM);

    logic signed [31:0] r_mem [STORE_DEPTH];
    logic signed [31:0] r_rdata;

    logic [4:0]          r_cfg, n_cfg;
    logic [IDX_W-1:0]    r_head, n_head;
    logic [IDX_W-1:0]    r_tail, n_tail;
    logic [IDX_W-1:0]    r_ptr, n_ptr;
    logic [4:0]          r_count, n_count;
    logic [4:0]          r_left, n_left;
    logic                r_first, n_first;
    logic [2:0]          r_op, n_op;
    logic signed [31:0]  r_val, n_val;
    logic signed [31:0]  r_res_value, n_res_value;
    logic                r_found, n_found;
    logic [1:0]          r_res_status, n_res_status;

    logic [4:0] w_cap;
    logic       w_full;
    logic       w_empty;
    logic       w_we;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                   input logic [4:0] cap);
        logic [NW-1:0] n;
        n = NW'(idx) + NW'(1);
        ring_next = (n >= NW'(cap)) ? '0 : IDX_W'(n);
    endfunction

    // clamp the programmed capacity into one..depth, and to at most 31
    always_comb begin
        if (r_cfg == 5'd0) begin
            w_cap = 5'd1;
        end else if (r_cfg > CAP_MAX) begin
            w_cap = CAP_MAX;
        end else begin
            w_cap = r_cfg;
        end
    end

    assign w_full  = (r_count >= w_cap);
    assign w_empty = (r_count == 5'd0);
    assign w_we    = i_cmd.enq && !w_full;

    always_comb begin
        n_cfg        = r_cfg;
        n_head       = r_head;
        n_tail       = r_tail;
        n_ptr        = r_ptr;
        n_count      = r_count;
        n_left       = r_left;
        n_first      = r_first;
        n_op         = r_op;
        n_val        = r_val;
        n_res_value  = r_res_value;
        n_found      = r_found;
        n_res_status = r_res_status;

        if (i_cmd.capture) begin
            n_op         = i_in.operation;
            n_val        = i_in.value;
            n_res_value  = cfsm_pkg::NONE_WORD;
            n_found      = 1'b0;
            n_res_status = cfsm_pkg::ST_OK;
        end

        if (i_cmd.enq) begin
            if (w_full) begin
                n_res_status = cfsm_pkg::ST_OVERFLOW;
            end else begin
                n_tail  = ring_next(r_tail, w_cap);
                n_count = r_count + 5'd1;
            end
        end

        if (i_cmd.set_empty) begin
            n_res_status = cfsm_pkg::ST_EMPTY;
        end

        if (i_cmd.clear) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end

        if (i_cmd.scan_init) begin
            n_ptr   = r_head;
            n_first = 1'b1;
            // dequeue and peek look at the head entry only
            if ((r_op == cfsm_pkg::OP_SEARCH) || (r_op == cfsm_pkg::OP_MINIMUM)) begin
                n_left = r_count;
            end else begin
                n_left = 5'd1;
            end
        end

        if (i_cmd.scan_fetch) begin
            n_ptr = ring_next(r_ptr, w_cap);
        end

        if (i_cmd.scan_step) begin
            n_ptr   = ring_next(r_ptr, w_cap);
            n_left  = r_left - 5'd1;
            n_first = 1'b0;
            unique case (r_op)
                cfsm_pkg::OP_SEARCH: begin
                    if (r_rdata == r_val) begin
                        n_found = 1'b1;
                    end
                end
                cfsm_pkg::OP_MINIMUM: begin
                    if (r_first || (r_rdata < r_res_value)) begin
                        n_res_value = r_rdata;
                    end
                end
                cfsm_pkg::OP_DEQUEUE: begin
                    n_res_value = r_rdata;
                    n_head      = ring_next(r_head, w_cap);
                    n_count     = r_count - 5'd1;
                end
                cfsm_pkg::OP_PEEK: begin
                    n_res_value = r_rdata;
                end
                default: begin
                end
            endcase
        end

        // a capacity write also empties the ring
        if (i_cfg_we) begin
            n_cfg   = i_cfg_wdata;
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= cfsm_pkg::CAP_RESET;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_cfg   <= n_cfg;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_left       <= n_left;
        r_first      <= n_first;
        r_op         <= n_op;
        r_val        <= n_val;
        r_res_value  <= n_res_value;
        r_found      <= n_found;
        r_res_status <= n_res_status;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_tail] <= r_val;
        end
        r_rdata <= r_mem[r_ptr];
    end

    assign o_status.op        = r_op;
    assign o_status.empty     = w_empty;
    assign o_status.scan_last = (r_left == 5'd1);

    assign o_result.result_value = r_res_value;
    assign o_result.found        = r_found;
    assign o_result.status       = r_res_status;
    assign o_result.entry_count  = r_count;
    assign o_result.is_empty     = w_empty;
    assign o_result.is_full      = (r_count == w_cap);

    `AST_IMPLY(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= w_cap)
    `AST_IMPLY(a_head_cap, i_clk, i_rst_n, 1'b1, r_head < w_cap)
    `AST_IMPLY(a_tail_cap, i_clk, i_rst_n, 1'b1, r_tail < w_cap)

endmodule

[hdl/cfsm_ctrl.sv]
`include "assert_macros.svh"

module cfsm_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  cfsm_pkg::t_dp_status   i_status,
    output cfsm_pkg::t_dp_cmd      o_cmd,
    output logic                   o_busy,
    output logic                   o_strobe
);

    cfsm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfsm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_busy   = 1'b1;
        o_strobe = 1'b0;

        unique case (r_state)
            cfsm_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = cfsm_pkg::S_EXEC;
                end
            end
            cfsm_pkg::S_EXEC: begin
                n_state = cfsm_pkg::S_RESP;
                unique case (i_status.op)
                    cfsm_pkg::OP_ENQUEUE: begin
                        o_cmd.enq = 1'b1;
                    end
                    cfsm_pkg::OP_DEQUEUE, cfsm_pkg::OP_PEEK, cfsm_pkg::OP_MINIMUM: begin
                        if (i_status.empty) begin
                            o_cmd.set_empty = 1'b1;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = cfsm_pkg::S_FETCH;
                        end
                    end
                    cfsm_pkg::OP_SEARCH: begin
                        // empty search reports not found with status ok
                        if (!i_status.empty) begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = cfsm_pkg::S_FETCH;
                        end
                    end
                    cfsm_pkg::OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            cfsm_pkg::S_FETCH: begin
                o_cmd.scan_fetch = 1'b1;
                n_state          = cfsm_pkg::S_SCAN;
            end
            cfsm_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = cfsm_pkg::S_RESP;
                end
            end
            cfsm_pkg::S_RESP: begin
                o_strobe = 1'b1;
                n_state  = cfsm_pkg::S_IDLE;
            end
            default: begin
                n_state = cfsm_pkg::S_IDLE;
            end
        endcase
    end

    `AST_NEXT(a_accept_exec, i_clk, i_rst_n, i_start && !o_busy, r_state == cfsm_pkg::S_EXEC)
    `AST_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe && !o_busy)
    `AST_NEXT(a_fetch_scan, i_clk, i_rst_n, o_cmd.scan_fetch, o_cmd.scan_step)

endmodule

[hdl/circular_fifo_with_search_min_unit.sv]
// Ring-buffer FIFO of signed 32-bit words with search and minimum.
//
// Input: drive i_in (operation, value) and raise start; the item transfers
// at a rising edge where start is high and busy is low. One item is in
// flight at a time; busy stays high until its result has been shown.
// Output: o_result is valid for exactly one cycle while o_strobe is high.
// There is no back-pressure: the receiver must take every result.
// States from transfer to strobe: execute, then per operation, ending in
//   the response state that raises the strobe:
//   enqueue, clear, unused codes, any empty case: straight to response.
//   dequeue, peek: fetch, a scan step on the head entry, response.
//   search, minimum over N stored entries: fetch, a scan step per entry,
//     response; the scan reads one entry a cycle through the store port.
// Configuration: i_cfg_we with i_cfg_wdata writes the capacity and empties
// the FIFO; the user must write only while idle, unchecked by the block.
// Reset (i_rst_n low, synchronous) empties the FIFO and sets the capacity
// to 16; the store contents are left as they were.
module circular_fifo_with_search_min_unit #(
    parameter int STORE_DEPTH = cfsm_pkg::STORE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  cfsm_pkg::t_in   i_in,
    input  logic            i_cfg_we,
    input  logic [4:0]      i_cfg_wdata,
    output logic            o_strobe,
    output cfsm_pkg::t_out  o_result
);

    cfsm_pkg::t_dp_cmd    w_cmd;
    cfsm_pkg::t_dp_status w_status;

    cfsm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    cfsm_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_result    (o_result)
    );

endmodule
